[sv/rsol_pkg.sv]
// ----------------------------------------------------------------------------
// rsol_pkg
// shared types and constants for the ring store with offset lookup
// ----------------------------------------------------------------------------
`default_nettype none

package rsol_pkg;

    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // opcode values
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] new_handle;
        logic [31:0] new_length;
        logic [31:0] char_position;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] hit_handle;
        logic [31:0] hit_length;
        logic [31:0] byte_offset;
        logic        evicted_valid;
        logic [31:0] evicted_handle;
    } rsp_t;

    // one ring entry
    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] length;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_FIND
    } state_t;

endpackage

`default_nettype wire

[sv/rsol_ram.sv]
// ----------------------------------------------------------------------------
// rsol_ram
// entry memory: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module rsol_ram (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [rsol_pkg::SLOT_W-1:0] wr_addr,
    input  wire rsol_pkg::entry_t            wr_data,
    input  wire logic                        rd_en,
    input  wire logic [rsol_pkg::SLOT_W-1:0] rd_addr,
    output rsol_pkg::entry_t                 rd_data
);

    rsol_pkg::entry_t mem [rsol_pkg::RING_DEPTH];
    rsol_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/ring_store_offset_lookup_top.sv]
// ----------------------------------------------------------------------------
// ring_store_offset_lookup_top
// ring of handle/length entries with oldest-first overwrite and offset lookup
// ----------------------------------------------------------------------------
// add: passes through ST_ADD, which writes the entry; the result strobe is registered as it returns to idle
// find: one entry per cycle through the compare/subtract unit in ST_FIND,
//   result strobed in the cycle after the walk ends
// an empty ring answers a find in the cycle after acceptance without going busy
// the next transaction may be accepted at the edge that ends the strobe cycle
// results cannot be stalled; reset clears slots, full flag and sequencer, not the ram
`default_nettype none

module ring_store_offset_lookup_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rsol_pkg::req_t req,
    output logic                done,
    output rsol_pkg::rsp_t      rsp
);

    localparam int SLOT_W = rsol_pkg::SLOT_W;
    localparam int CNT_W  = rsol_pkg::CNT_W;

    // wrap-around increment of a slot index
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(rsol_pkg::RING_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    // sequencer and ring pointers
    rsol_pkg::state_t  state_reg, state_next;
    rsol_pkg::req_t    req_reg, req_next;
    logic [SLOT_W-1:0] wr_reg, wr_next;
    logic [SLOT_W-1:0] rd_reg, rd_next;
    logic              full_reg, full_next;

    // walk state for a find
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       pos_reg, pos_next;

    // result register
    logic              done_reg, done_next;
    rsol_pkg::rsp_t    rsp_reg, rsp_next;

    // entry ram port signals
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    rsol_pkg::entry_t  ram_wr_data;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_addr;
    rsol_pkg::entry_t  ram_rd_data;

    logic [CNT_W-1:0]  valid_count;
    logic [SLOT_W-1:0] wr_inc;
    logic [SLOT_W-1:0] slot_inc;

    rsol_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // number of stored entries: depth when full, else write minus read mod depth
    always_comb
    begin
        if (full_reg)
        begin
            valid_count = CNT_W'(rsol_pkg::RING_DEPTH);
        end
        else if (wr_reg >= rd_reg)
        begin
            valid_count = CNT_W'(wr_reg - rd_reg);
        end
        else
        begin
            valid_count = CNT_W'(rsol_pkg::RING_DEPTH) - CNT_W'(rd_reg) + CNT_W'(wr_reg);
        end
    end

    assign wr_inc   = next_slot(wr_reg);
    assign slot_inc = next_slot(slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsol_pkg::ST_IDLE;
            wr_reg    <= '0;
            rd_reg    <= '0;
            full_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            full_reg  <= full_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        slot_reg <= slot_next;
        pos_reg  <= pos_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        wr_next     = wr_reg;
        rd_next     = rd_reg;
        full_next   = full_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_reg;
        ram_wr_data = '{handle: req_reg.new_handle, length: req_reg.new_length};
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_reg;

        unique case (state_reg)
            rsol_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    // oldest entry fetched in both cases
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_reg;
                    if (req.opcode == rsol_pkg::OP_ADD)
                    begin
                        state_next = rsol_pkg::ST_ADD;
                    end
                    else
                    begin
                        count_next = valid_count;
                        pos_next   = req.char_position;
                        slot_next  = rd_reg;
                        if (valid_count == '0)
                        begin
                            // empty ring, answer not found at once
                            done_next = 1'b1;
                            rsp_next  = '0;
                        end
                        else
                        begin
                            state_next = rsol_pkg::ST_FIND;
                        end
                    end
                end
            end

            rsol_pkg::ST_ADD:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wr_reg;
                rsp_next    = '0;
                if (full_reg)
                begin
                    // overwrite oldest: report it and advance the read slot
                    rsp_next.evicted_valid  = 1'b1;
                    rsp_next.evicted_handle = ram_rd_data.handle;
                    rd_next                 = next_slot(rd_reg);
                end
                wr_next    = wr_inc;
                full_next  = (wr_inc == rd_next);
                done_next  = 1'b1;
                state_next = rsol_pkg::ST_IDLE;
            end

            rsol_pkg::ST_FIND:
            begin
                if (ram_rd_data.length > pos_reg)
                begin
                    rsp_next             = '0;
                    rsp_next.found       = 1'b1;
                    rsp_next.hit_handle  = ram_rd_data.handle;
                    rsp_next.hit_length  = ram_rd_data.length;
                    rsp_next.byte_offset = pos_reg;
                    done_next            = 1'b1;
                    state_next           = rsol_pkg::ST_IDLE;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    // walked past the last stored byte
                    rsp_next   = '0;
                    done_next  = 1'b1;
                    state_next = rsol_pkg::ST_IDLE;
                end
                else
                begin
                    pos_next    = pos_reg - ram_rd_data.length;
                    slot_next   = slot_inc;
                    count_next  = count_reg - CNT_W'(1);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = slot_inc;
                end
            end

            default:
            begin
                state_next = rsol_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != rsol_pkg::ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // a full ring has its slots meeting
    a_full_slots : assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (wr_reg == rd_reg))
        else $error("full flag set with write and read slots apart");

    // a walk never runs with no entries left or more than the ring holds
    a_walk_count : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsol_pkg::ST_FIND) |->
            ((count_reg != '0) && (count_reg <= CNT_W'(rsol_pkg::RING_DEPTH))))
        else $error("find walk count out of range");

    // an add completes in the following cycle
    a_add_done : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rsol_pkg::ST_ADD) |=> (done && (state_reg == rsol_pkg::ST_IDLE)))
        else $error("add did not complete");

    // a result never carries both a hit and an eviction
    a_rsp_kind : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.found && rsp.evicted_valid))
        else $error("result mixes find and add fields");

endmodule

`default_nettype wire
